>>> hdl/stdo_pkg.sv
// Shared types and constants for the super-twisting disturbance observer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package stdo_pkg;

  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_INVERSE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMITS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMITS     = 3'd6;

  // Register reset values
  localparam logic signed [31:0] GAIN_ONE       = 32'sd65536;
  localparam logic signed [31:0] GAIN_ZERO      = 32'sd0;
  localparam logic [31:0]        LIMITS_FULL    = 32'h7FFF_8000;

  // Square root unit: 15 result bits, one per step
  localparam int ROOT_W = 15;

  // Datapath operation issued by the controller in one cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,   // capture input transaction
    OP_ERR,    // speed error, start square root
    OP_MUL,    // register one gain product
    OP_SGN,    // boundary-layer sign
    OP_DIST,   // disturbance update and clamp
    OP_TQ,     // torque term minus disturbance
    OP_PU,     // root times sign
    OP_NL,     // subtract nonlinear term
    OP_SPD,    // speed update and clamp
    OP_OUT     // load output register
  } op_t;

  // Operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_SGN,
    MUL_DIST,
    MUL_TORQUE,
    MUL_ROOT,
    MUL_NONLIN,
    MUL_MODEL
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_SGN,
    ST_WB_SGN,
    ST_MUL_DIST,
    ST_WB_DIST,
    ST_MUL_TQ,
    ST_WB_TQ,
    ST_MUL_PU,
    ST_WB_PU,
    ST_MUL_NL,
    ST_WB_NL,
    ST_MUL_SPD,
    ST_WB_SPD,
    ST_OUT,
    ST_SPARE
  } state_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t mul_sel;
  } cmd_t;

  typedef struct packed {
    logic root_done;
    logic out_full;
  } status_t;

endpackage

>>> hdl/stdo_if.sv
// Channel interfaces for the observer: input samples, results, register writes.
// Depends on stdo_pkg for the register index width.
interface stdo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] current_q;
  logic signed [15:0] measured_speed;
  modport source (output valid, current_q, measured_speed, input ready);
  modport sink   (input valid, current_q, measured_speed, output ready);
endinterface

interface stdo_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] estimated_speed;
  logic signed [15:0] disturbance;
  modport source (output valid, estimated_speed, disturbance, input ready);
  modport sink   (input valid, estimated_speed, disturbance, output ready);
endinterface

interface stdo_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [stdo_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/stdo_sqrt.sv
// Bit-serial integer square root: floor(sqrt(x * 32768)), one result bit per cycle.
// Depends on stdo_pkg for the result width.
module stdo_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [stdo_pkg::ROOT_W-1:0]   x,
  output logic                          busy,
  output logic [stdo_pkg::ROOT_W-1:0]   root
);

  logic        busy_r, busy_nxt;
  logic [29:0] n_r, n_nxt;
  logic [30:0] res_r, res_nxt;
  logic [28:0] bit_r, bit_nxt;
  logic [30:0] trial;

  assign trial = res_r + {2'b00, bit_r};

  always_comb begin
    busy_nxt = busy_r;
    n_nxt    = n_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      n_nxt    = {x, 15'd0};
      res_nxt  = '0;
      bit_nxt  = {1'b1, 28'd0};
    end else if (busy_r) begin
      if ({1'b0, n_r} >= trial) begin
        n_nxt   = n_r - trial[29:0];
        res_nxt = (res_r >> 1) + {2'b00, bit_r};
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt  = bit_r >> 2;
      busy_nxt = !bit_r[0];   // last step uses the lowest bit
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[stdo_pkg::ROOT_W-1:0];

endmodule

>>> hdl/stdo_datapath.sv
// Observer datapath: config registers, estimate state, shared gain multiplier,
// square root unit and output register. Depends on stdo_pkg, stdo_if, stdo_sqrt.
module stdo_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  stdo_pkg::cmd_t    cmd,
  output stdo_pkg::status_t status,
  stdo_in_if.sink           in_ch,
  stdo_out_if.source        out_ch,
  stdo_cfg_if.sink          cfg_ch
);

  // Configuration
  logic signed [31:0] torque_gain_r, model_gain_r, root_gain_r;
  logic signed [31:0] integral_gain_r, boundary_inverse_r;
  logic [31:0]        dist_limits_r, speed_limits_r;

  // Working registers
  logic signed [15:0] iq_r, meas_r, err_r, sgn_r, pu_r, drive_r;
  logic [14:0]        mag_nxt;
  logic signed [15:0] spd_r, dist_r;
  logic signed [47:0] prod_r;
  logic signed [15:0] out_spd_r, out_dist_r;
  logic               out_valid_r;

  logic signed [31:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [15:0] gres;
  logic signed [15:0] err_nxt;
  logic               sqrt_busy;
  logic [stdo_pkg::ROOT_W-1:0] root;

  function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
    if (v > 17'sd32767)       return 16'sh7FFF;
    else if (v < -17'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  function automatic logic signed [15:0] clamp(input logic signed [15:0] v,
                                               input logic [31:0] lim);
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    lo = lim[15:0];
    hi = lim[31:16];
    if (v < lo)      return lo;
    else if (v > hi) return hi;
    else             return v;
  endfunction

  // Product >>> 16, saturated to Q15
  logic signed [31:0] prod_sh;
  assign prod_sh = prod_r[47:16];
  assign gres = (prod_sh > 32'sd32767)  ? 16'sh7FFF :
                (prod_sh < -32'sd32768) ? 16'sh8000 : prod_sh[15:0];

  assign err_nxt = sat17(17'(spd_r) - 17'(meas_r));

  // |err| saturates: -32768 maps to 32767; feeds the square root as it starts
  assign mag_nxt = err_nxt[15] ? ((err_nxt == 16'sh8000) ? 15'h7FFF : 15'(-err_nxt))
                               : err_nxt[14:0];

  always_comb begin
    mul_a = torque_gain_r;
    mul_b = iq_r;
    unique case (cmd.mul_sel)
      stdo_pkg::MUL_SGN:    begin mul_a = boundary_inverse_r; mul_b = err_r; end
      stdo_pkg::MUL_DIST:   begin mul_a = integral_gain_r;    mul_b = sgn_r; end
      stdo_pkg::MUL_TORQUE: begin mul_a = torque_gain_r;      mul_b = iq_r;  end
      stdo_pkg::MUL_ROOT:   begin mul_a = {16'd0, root, 1'b0}; mul_b = sgn_r; end
      stdo_pkg::MUL_NONLIN: begin mul_a = root_gain_r;        mul_b = pu_r;  end
      stdo_pkg::MUL_MODEL:  begin mul_a = model_gain_r;       mul_b = drive_r; end
      default:              begin mul_a = torque_gain_r;      mul_b = iq_r;  end
    endcase
  end

  stdo_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == stdo_pkg::OP_ERR),
    .x     (mag_nxt),
    .busy  (sqrt_busy),
    .root  (root)
  );

  // Config writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      torque_gain_r      <= stdo_pkg::GAIN_ONE;
      model_gain_r       <= stdo_pkg::GAIN_ZERO;
      root_gain_r        <= stdo_pkg::GAIN_ZERO;
      integral_gain_r    <= stdo_pkg::GAIN_ZERO;
      boundary_inverse_r <= stdo_pkg::GAIN_ONE;
      dist_limits_r      <= stdo_pkg::LIMITS_FULL;
      speed_limits_r     <= stdo_pkg::LIMITS_FULL;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        stdo_pkg::CFG_TORQUE_GAIN:      torque_gain_r      <= cfg_ch.data;
        stdo_pkg::CFG_MODEL_GAIN:       model_gain_r       <= cfg_ch.data;
        stdo_pkg::CFG_ROOT_GAIN:        root_gain_r        <= cfg_ch.data;
        stdo_pkg::CFG_INTEGRAL_GAIN:    integral_gain_r    <= cfg_ch.data;
        stdo_pkg::CFG_BOUNDARY_INVERSE: boundary_inverse_r <= cfg_ch.data;
        stdo_pkg::CFG_DIST_LIMITS:      dist_limits_r      <= cfg_ch.data;
        stdo_pkg::CFG_SPEED_LIMITS:     speed_limits_r     <= cfg_ch.data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Estimate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_r  <= '0;
      dist_r <= '0;
    end else begin
      if (cmd.op == stdo_pkg::OP_DIST) dist_r <= clamp(sat17(17'(dist_r) + 17'(gres)),
                                                       dist_limits_r);
      if (cmd.op == stdo_pkg::OP_SPD)  spd_r  <= clamp(sat17(17'(spd_r) + 17'(gres)),
                                                       speed_limits_r);
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      stdo_pkg::OP_LOAD: begin
        iq_r   <= in_ch.current_q;
        meas_r <= in_ch.measured_speed;
      end
      stdo_pkg::OP_ERR: err_r   <= err_nxt;
      stdo_pkg::OP_MUL: prod_r  <= mul_a * mul_b;
      stdo_pkg::OP_SGN: sgn_r   <= gres;
      stdo_pkg::OP_TQ:  drive_r <= sat17(17'(gres) - 17'(dist_r));
      stdo_pkg::OP_PU:  pu_r    <= gres;
      stdo_pkg::OP_NL:  drive_r <= sat17(17'(drive_r) - 17'(gres));
      stdo_pkg::OP_OUT: begin
        out_spd_r  <= spd_r;
        out_dist_r <= dist_r;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == stdo_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.estimated_speed = out_spd_r;
  assign out_ch.disturbance     = out_dist_r;

  assign status.root_done = !sqrt_busy;
  assign status.out_full  = out_valid_r && !out_ch.ready;

  // Root product is only issued once the square root has settled
  a_root_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == stdo_pkg::OP_MUL && cmd.mul_sel == stdo_pkg::MUL_ROOT) |-> !sqrt_busy)
    else $error("root product issued while square root busy");

  // A new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == stdo_pkg::OP_OUT) |-> (!out_valid_r || out_ch.ready))
    else $error("output register overwritten");

  // Square root is only started when idle
  a_sqrt_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == stdo_pkg::OP_ERR) |-> !sqrt_busy)
    else $error("square root restarted while busy");

endmodule

>>> hdl/stdo_ctrl.sv
// Sequencer for one observer sample: issues datapath operations in order.
// Depends on stdo_pkg for state, command and status types.
module stdo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stdo_pkg::status_t status,
  output stdo_pkg::cmd_t    cmd
);

  stdo_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stdo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.op      = stdo_pkg::OP_NONE;
    cmd.mul_sel = stdo_pkg::MUL_SGN;
    unique case (state_r)
      stdo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = stdo_pkg::OP_LOAD;
          state_nxt = stdo_pkg::ST_ERR;
        end
      end
      stdo_pkg::ST_ERR: begin
        cmd.op    = stdo_pkg::OP_ERR;
        state_nxt = stdo_pkg::ST_MUL_SGN;
      end
      stdo_pkg::ST_MUL_SGN: begin
        cmd.op      = stdo_pkg::OP_MUL;
        cmd.mul_sel = stdo_pkg::MUL_SGN;
        state_nxt   = stdo_pkg::ST_WB_SGN;
      end
      stdo_pkg::ST_WB_SGN: begin
        cmd.op    = stdo_pkg::OP_SGN;
        state_nxt = stdo_pkg::ST_MUL_DIST;
      end
      stdo_pkg::ST_MUL_DIST: begin
        cmd.op      = stdo_pkg::OP_MUL;
        cmd.mul_sel = stdo_pkg::MUL_DIST;
        state_nxt   = stdo_pkg::ST_WB_DIST;
      end
      stdo_pkg::ST_WB_DIST: begin
        cmd.op    = stdo_pkg::OP_DIST;
        state_nxt = stdo_pkg::ST_MUL_TQ;
      end
      stdo_pkg::ST_MUL_TQ: begin
        cmd.op      = stdo_pkg::OP_MUL;
        cmd.mul_sel = stdo_pkg::MUL_TORQUE;
        state_nxt   = stdo_pkg::ST_WB_TQ;
      end
      stdo_pkg::ST_WB_TQ: begin
        cmd.op    = stdo_pkg::OP_TQ;
        state_nxt = stdo_pkg::ST_MUL_PU;
      end
      stdo_pkg::ST_MUL_PU: begin
        // hold until the square root is finished
        if (status.root_done) begin
          cmd.op      = stdo_pkg::OP_MUL;
          cmd.mul_sel = stdo_pkg::MUL_ROOT;
          state_nxt   = stdo_pkg::ST_WB_PU;
        end
      end
      stdo_pkg::ST_WB_PU: begin
        cmd.op    = stdo_pkg::OP_PU;
        state_nxt = stdo_pkg::ST_MUL_NL;
      end
      stdo_pkg::ST_MUL_NL: begin
        cmd.op      = stdo_pkg::OP_MUL;
        cmd.mul_sel = stdo_pkg::MUL_NONLIN;
        state_nxt   = stdo_pkg::ST_WB_NL;
      end
      stdo_pkg::ST_WB_NL: begin
        cmd.op    = stdo_pkg::OP_NL;
        state_nxt = stdo_pkg::ST_MUL_SPD;
      end
      stdo_pkg::ST_MUL_SPD: begin
        cmd.op      = stdo_pkg::OP_MUL;
        cmd.mul_sel = stdo_pkg::MUL_MODEL;
        state_nxt   = stdo_pkg::ST_WB_SPD;
      end
      stdo_pkg::ST_WB_SPD: begin
        cmd.op    = stdo_pkg::OP_SPD;
        state_nxt = stdo_pkg::ST_OUT;
      end
      stdo_pkg::ST_OUT: begin
        if (!status.out_full) begin
          cmd.op    = stdo_pkg::OP_OUT;
          state_nxt = stdo_pkg::ST_IDLE;
        end
      end
      stdo_pkg::ST_SPARE: begin
        state_nxt = stdo_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/super_twisting_disturbance_observer_core.sv
// Super-twisting disturbance observer, top level. Depends on stdo_pkg, stdo_if,
// stdo_ctrl and stdo_datapath.
//
// Each input transaction carries one sample (q-axis current, measured speed, Q15)
// and produces exactly one output transaction with the updated speed estimate and
// disturbance estimate. The time from acceptance of a sample to the next point
// at which in_ch.ready is high is set by the 15-step bit-serial square root,
// which starts as the speed error is registered, and by the single shared
// 32x16 gain multiplier that the six products pass through one after
// another (product registered, then shifted, saturated and written back). The
// result sits in an output register, so a waiting result only holds the block
// if a second result is ready before the first has been taken.
// Register writes on cfg_ch are always accepted; write them only while no
// sample is in flight. All arithmetic saturates to Q15; clamps test the
// minimum first, then the maximum.
module super_twisting_disturbance_observer_core (
  input  logic       clk,
  input  logic       rst_n,
  stdo_in_if.sink    in_ch,
  stdo_out_if.source out_ch,
  stdo_cfg_if.sink   cfg_ch
);

  // controller <-> datapath
  stdo_pkg::cmd_t    cmd;
  stdo_pkg::status_t status;

  stdo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  stdo_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .status (status),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // A sample in flight blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second sample accepted while one is in flight");

  // No result rises too soon after an accepted sample
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> ##1 !$rose(out_ch.valid))
    else $error("result appeared too soon after a sample");

  // A load of the input captures only on acceptance
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == stdo_pkg::OP_LOAD) |-> (in_ch.valid && in_ch.ready))
    else $error("input captured without a transaction");

endmodule

>>> tb/super_twisting_disturbance_observer_core_tb.sv
// Testbench for super_twisting_disturbance_observer_core: directed and random samples
// under several register settings, checked against a cycle-free predictor of the observer.
// Depends on stdo_pkg, stdo_if and the observer RTL.
module super_twisting_disturbance_observer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; writes there must change nothing
  localparam logic [stdo_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RAND_PHASES   = 8;
  localparam int RAND_PER_PHASE = 200;

  typedef struct packed {
    logic signed [15:0] spd;
    logic signed [15:0] disturb;
  } obs_result_t;

  typedef struct {
    logic signed [15:0] iq;
    logic signed [15:0] meas;
    bit                 drain_first;  // hold off until every result is back
  } sample_t;

  logic clk;
  logic rst_n;

  stdo_in_if  in_bus();
  stdo_out_if out_bus();
  stdo_cfg_if cfg_bus();

  super_twisting_disturbance_observer_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  sample_t     sample_queue[$];   // samples waiting to be driven
  obs_result_t est_queue[$];      // predicted estimates, oldest first
  int          err_count;
  int          cycle_count;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int          in_wait;
  int          out_stall;

  // Predictor copy of the register file and observer state
  logic signed [31:0] torque_g, model_g, root_g, integ_g, binv_g;
  logic [31:0]        dist_lim, speed_lim;
  logic signed [15:0] spd_est, dist_est;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] sat_q15(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Q16.16 gain times Q15, floor shift by 16, saturate
  function automatic logic signed [15:0] gain_scale(logic signed [31:0] g,
                                                    logic signed [15:0] x);
    longint p;
    p = longint'(g) * longint'(x);
    return sat_q15(p >>> 16);
  endfunction

  function automatic logic signed [15:0] q15_mul(logic signed [15:0] a,
                                                 logic signed [15:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat_q15(p >>> 15);
  endfunction

  // Minimum is tested first, so an inverted window still resolves
  function automatic logic signed [15:0] clamp_q15(logic signed [15:0] x, logic [31:0] lim);
    logic signed [15:0] lo, hi;
    lo = lim[15:0];
    hi = lim[31:16];
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // floor(sqrt(x * 2^15)) by bitwise search
  function automatic logic signed [15:0] root_q15(logic signed [15:0] x);
    longint n, r, t;
    if (x <= 0) return 16'sd0;
    n = longint'(x) <<< 15;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (longint'(1) <<< b);
      if (t * t <= n) r = t;
    end
    return r[15:0];
  endfunction

  // One observer update; advances the predictor state
  function automatic obs_result_t observe_sample(logic signed [15:0] iq,
                                                 logic signed [15:0] meas);
    logic signed [15:0] err, sgn, mag, nl, drv;
    obs_result_t res;
    err = sat_q15(longint'(spd_est) - longint'(meas));
    sgn = gain_scale(binv_g, err);
    dist_est = clamp_q15(sat_q15(longint'(dist_est) + longint'(gain_scale(integ_g, sgn))),
                         dist_lim);
    mag = (err < 0) ? sat_q15(-longint'(err)) : err;
    nl  = gain_scale(root_g, q15_mul(root_q15(mag), sgn));
    drv = sat_q15(longint'(gain_scale(torque_g, iq)) - longint'(dist_est));
    drv = sat_q15(longint'(drv) - longint'(nl));
    spd_est = clamp_q15(sat_q15(longint'(spd_est) + longint'(gain_scale(model_g, drv))),
                        speed_lim);
    res.spd     = spd_est;
    res.disturb = dist_est;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_gain();
    int v;
    v = int'($urandom_range(0, 262144)) - 131072;
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom();
      default: return v;
    endcase
  endfunction

  // {max, min}; sometimes full range, sometimes inverted
  function automatic logic [31:0] pick_limits();
    logic [15:0] a, b;
    a = $urandom();
    b = $urandom();
    case ($urandom_range(0, 5))
      0, 1: return stdo_pkg::LIMITS_FULL;
      2: return {a, b};
      default: return ($signed(a) < $signed(b)) ? {b, a} : {a, b};
    endcase
  endfunction

  function automatic int edge_q15();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic push_sample(int iq, int meas, bit drain);
    sample_t s;
    s.iq = 16'(iq);
    s.meas = 16'(meas);
    s.drain_first = drain;
    sample_queue.push_back(s);
  endtask

  task automatic write_reg(logic [stdo_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic program_regs(logic [31:0] tq, logic [31:0] md, logic [31:0] rt,
                              logic [31:0] ig, logic [31:0] bi, logic [31:0] dl,
                              logic [31:0] sl);
    write_reg(stdo_pkg::CFG_TORQUE_GAIN, tq);
    write_reg(stdo_pkg::CFG_MODEL_GAIN, md);
    write_reg(stdo_pkg::CFG_ROOT_GAIN, rt);
    write_reg(stdo_pkg::CFG_INTEGRAL_GAIN, ig);
    write_reg(stdo_pkg::CFG_BOUNDARY_INVERSE, bi);
    write_reg(stdo_pkg::CFG_DIST_LIMITS, dl);
    write_reg(stdo_pkg::CFG_SPEED_LIMITS, sl);
  endtask

  // Drain: everything driven, every result back, then let the block settle
  task automatic wait_idle();
    while (sample_queue.size() != 0 || est_queue.size() != 0 || in_bus.valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and cycle guard
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample driver: one transaction in flight on in_bus, random gap after each while tx_idle_en is set.
  // A sample flagged drain_first is held until the result queue is empty.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_samples
    sample_t s;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_wait      <= 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_wait != 0) begin
        in_bus.valid <= 1'b0;
        in_wait      <= in_wait - 1;
      end else if (sample_queue.size() != 0 &&
                   (!sample_queue[0].drain_first ||
                    (!in_bus.valid && est_queue.size() == 0))) begin
        s = sample_queue.pop_front();
        in_bus.valid          <= 1'b1;
        in_bus.current_q      <= s.iq;
        in_bus.measured_speed <= s.meas;
        in_wait <= tx_idle_en ? int'($urandom_range(0, 13)) : 0;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: while rx_idle_en is set, after each accepted transaction stall ready a random count
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ready
    int n;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_stall     <= 0;
    end else if (out_bus.valid && out_bus.ready) begin
      n = rx_idle_en ? int'($urandom_range(0, 13)) : 0;
      out_bus.ready <= (n == 0);
      out_stall     <= n;
    end else if (out_stall != 0) begin
      out_bus.ready <= (out_stall == 1);
      out_stall     <= out_stall - 1;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and predictor. Results are checked before the sample accepted on
  // the same edge is predicted, so queue order never depends on block order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_and_predict
    obs_result_t want, got;
    if (!rst_n) begin
      torque_g  = stdo_pkg::GAIN_ONE;
      model_g   = stdo_pkg::GAIN_ZERO;
      root_g    = stdo_pkg::GAIN_ZERO;
      integ_g   = stdo_pkg::GAIN_ZERO;
      binv_g    = stdo_pkg::GAIN_ONE;
      dist_lim  = stdo_pkg::LIMITS_FULL;
      speed_lim = stdo_pkg::LIMITS_FULL;
      spd_est   = '0;
      dist_est  = '0;
      est_queue.delete();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.spd     = out_bus.estimated_speed;
        got.disturb = out_bus.disturbance;
        if (est_queue.size() == 0) begin
          $display("%0t: result with none expected: speed %0d disturbance %0d",
                   $time, got.spd, got.disturb);
          err_count++;
        end else begin
          want = est_queue.pop_front();
          if (got.spd !== want.spd) begin
            $display("%0t: estimated_speed mismatch: expected %0d actual %0d",
                     $time, want.spd, got.spd);
            err_count++;
          end
          if (got.disturb !== want.disturb) begin
            $display("%0t: disturbance mismatch: expected %0d actual %0d",
                     $time, want.disturb, got.disturb);
            err_count++;
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          stdo_pkg::CFG_TORQUE_GAIN:      torque_g  = cfg_bus.data;
          stdo_pkg::CFG_MODEL_GAIN:       model_g   = cfg_bus.data;
          stdo_pkg::CFG_ROOT_GAIN:        root_g    = cfg_bus.data;
          stdo_pkg::CFG_INTEGRAL_GAIN:    integ_g   = cfg_bus.data;
          stdo_pkg::CFG_BOUNDARY_INVERSE: binv_g    = cfg_bus.data;
          stdo_pkg::CFG_DIST_LIMITS:      dist_lim  = cfg_bus.data;
          stdo_pkg::CFG_SPEED_LIMITS:     speed_lim = cfg_bus.data;
          default: ;           // unmapped index: ignored
        endcase
      end
      if (in_bus.valid && in_bus.ready)
        est_queue.push_back(observe_sample(in_bus.current_q, in_bus.measured_speed));
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int  traj, iq_i, meas_i, r;
    bit  drain;

    // Known values on every input from time zero
    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.current_q      = '0;
    in_bus.measured_speed = '0;
    out_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = stdo_pkg::CFG_TORQUE_GAIN;
    cfg_bus.data          = '0;
    err_count             = 0;
    cycle_count           = 0;
    tx_idle_en            = 1'b0;
    rx_idle_en            = 1'b0;
    traj                  = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: model gain zero keeps the speed estimate still
    push_sample(0, 0, 0);
    push_sample(32767, 32767, 0);
    push_sample(-32768, -32768, 0);
    push_sample(32767, -32768, 0);
    wait_idle();

    // Moderate gains; drive speed to both rails so the error saturates,
    // including the |-32768| case. Unmapped index written with junk.
    write_reg(CFG_IDX_UNUSED, 32'hDEAD_BEEF);
    program_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_2000,
                 32'h0004_0000, stdo_pkg::LIMITS_FULL, stdo_pkg::LIMITS_FULL);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    push_sample(32767, 0, 0);
    push_sample(32767, 0, 0);
    push_sample(32767, 0, 0);
    push_sample(0, -32768, 0);
    push_sample(-32768, 32767, 1);   // sender holds until all results are back
    push_sample(-32768, 32767, 0);
    push_sample(-32768, 32767, 0);
    push_sample(0, 32767, 0);
    push_sample(100, 100, 0);
    push_sample(-1, -1, 0);
    push_sample(16'h5555, 16'hAAAA, 0);
    wait_idle();

    // Extreme gains and inverted clamp windows (minimum above maximum)
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 32'hFF9C_0064, 32'h03E8_07D0);
    tx_idle_en = 1'b0;
    push_sample(32767, 0, 0);
    push_sample(-32768, 0, 0);
    push_sample(0, 32767, 0);
    push_sample(0, -32768, 0);
    push_sample(1234, -1234, 0);
    wait_idle();

    // Random phases: fresh settings each time; most samples follow a smooth
    // speed trajectory so the observer actually tracks, the rest are noise.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_UNUSED, $urandom());
      program_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                   pick_limits(), pick_limits());
      // First random phase runs back to back on both sides
      tx_idle_en = (p != 0) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (p != 0) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          traj += int'($urandom_range(0, 1600)) - 800;
          if (traj > 32767) traj = 32767;
          if (traj < -32768) traj = -32768;
          iq_i   = int'($urandom_range(0, 8000)) - 4000;
          meas_i = traj + int'($urandom_range(0, 64)) - 32;
          if (meas_i > 32767) meas_i = 32767;
          if (meas_i < -32768) meas_i = -32768;
        end else if (r < 8) begin
          iq_i   = $urandom();
          meas_i = $urandom();
        end else begin
          iq_i   = edge_q15();
          meas_i = edge_q15();
        end
        drain = ($urandom_range(0, 63) == 0);
        push_sample(iq_i, meas_i, drain);
      end
      wait_idle();
    end

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
